@@ sv/ngss_pkg.sv @@
`default_nettype none

package ngss_pkg;

   // Algorithm constants
   localparam int MIN_TICKS    = 8;
   localparam int FRAC_BITS    = 16;
   localparam int IN_W         = 48;
   // Internal ladder starts at 1e-12; every value is scaled by 1e12 * 2^FRAC_BITS
   localparam int SCALE_DIGITS = 12;
   localparam int LW           = 88;        // IN_W-bit value times 1e12 fits here
   localparam int RW           = LW + 2;    // ladder register, one growth step of headroom
   localparam int CW           = RW + 6;    // ladder value times MIN_TICKS (up to 64)
   localparam int LADDER_LEN   = 99;        // 33 decades, three digits each
   localparam int IDX_W        = 7;
   localparam int DEC_W        = 6;
   localparam int PCNT_W       = 4;
   localparam int DIGITS_PER_DECADE = 3;
   // Highest decade the base step may take (1e19 on the internal ladder)
   localparam int TOP_BASE_DECADE   = 31;

   // Output exponent range
   localparam int EXP_W      = 5;
   localparam int MANT_W     = 2;
   localparam int OUT_EXP_LO = -4;
   localparam int OUT_EXP_HI = 9;
   localparam int DEC_SAT_LO = SCALE_DIGITS + OUT_EXP_LO;
   localparam int DEC_SAT_HI = SCALE_DIGITS + OUT_EXP_HI;

   // Division by three on ladder indexes below 128
   localparam int DIV3_MUL   = 43;
   localparam int DIV3_SHIFT = 7;

   // Leading digit codes
   localparam logic [MANT_W-1:0] MANT_ONE  = 2'd0;
   localparam logic [MANT_W-1:0] MANT_TWO  = 2'd1;
   localparam logic [MANT_W-1:0] MANT_FIVE = 2'd2;

   // Operand codes
   localparam logic [1:0] OPD_RANGE = 2'd0;
   localparam logic [1:0] OPD_LO    = 2'd1;
   localparam logic [1:0] OPD_HI    = 2'd2;

   // Compare kinds, one per scan phase
   localparam logic [1:0] CMP_RANGE_GT    = 2'd0;   // range above ladder value
   localparam logic [1:0] CMP_RANGE_TICKS = 2'd1;   // range at least MIN_TICKS ladder values
   localparam logic [1:0] CMP_LO_GT       = 2'd2;   // min spacing above ladder value
   localparam logic [1:0] CMP_HI_GE       = 2'd3;   // max spacing at or above ladder value

   typedef struct packed {
      logic       load;
      logic       prep_en;
      logic [1:0] prep_sel;
      logic       r_step;
      logic [1:0] digit;
      logic [1:0] cmp_sel;
   } ngss_arith_ctl_type;

   typedef struct packed {
      logic [DEC_W-1:0]  decade;
      logic [MANT_W-1:0] digit;
   } ngss_split_type;

   // Split a ladder index into decade and leading digit
   function automatic ngss_split_type ngss_split(input logic [IDX_W-1:0] idx);
      logic [IDX_W+5:0] prod;
      ngss_split_type   s;
      prod     = (IDX_W+6)'(idx) * (IDX_W+6)'(DIV3_MUL);
      s.decade = DEC_W'(prod >> DIV3_SHIFT);
      s.digit  = MANT_W'(idx - IDX_W'({s.decade, 1'b0}) - IDX_W'(s.decade));
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/ngss_arith.sv @@
`default_nettype none

module ngss_arith (
   input  logic                            clock,
   input  ngss_pkg::ngss_arith_ctl_type    ctl,
   input  logic [ngss_pkg::IN_W-1:0]       rng_load,
   input  logic [ngss_pkg::IN_W-1:0]       lo_load,
   input  logic [ngss_pkg::IN_W-1:0]       hi_load,
   output logic                            hit
);

   logic [ngss_pkg::LW-1:0] l_rng_ff;
   logic [ngss_pkg::LW-1:0] l_lo_ff;
   logic [ngss_pkg::LW-1:0] l_hi_ff;
   logic [ngss_pkg::RW-1:0] r_ff;

   logic [ngss_pkg::LW-1:0] l_prep;
   logic [ngss_pkg::LW-1:0] l_cmp;
   logic [ngss_pkg::RW-1:0] add_a;
   logic [ngss_pkg::RW-1:0] add_b;
   logic [ngss_pkg::RW-1:0] sum;
   logic [ngss_pkg::CW-1:0] cmp_a;
   logic [ngss_pkg::CW-1:0] cmp_b;
   logic                    a_gt;
   logic                    a_eq;
   logic                    ge_mode;

   // Pick the operand being scaled by ten
   always_comb begin
      unique case (ctl.prep_sel)
         ngss_pkg::OPD_RANGE: l_prep = l_rng_ff;
         ngss_pkg::OPD_LO:    l_prep = l_lo_ff;
         ngss_pkg::OPD_HI:    l_prep = l_hi_ff;
         default:             l_prep = l_rng_ff;
      endcase
   end

   // Shared shift-add unit: x*10 during scaling, next ladder value during the scan
   always_comb begin
      if (ctl.prep_en) begin
         add_a = ngss_pkg::RW'(l_prep) << 3;
         add_b = ngss_pkg::RW'(l_prep) << 1;
      end else begin
         add_a = r_ff << 1;
         add_b = (ctl.digit == ngss_pkg::MANT_TWO) ? (r_ff >> 1) : '0;
      end
      sum = add_a + add_b;
   end

   // Load, scale and advance the operand registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         l_rng_ff <= ngss_pkg::LW'(rng_load);
         l_lo_ff  <= ngss_pkg::LW'(lo_load);
         l_hi_ff  <= ngss_pkg::LW'(hi_load);
         r_ff     <= ngss_pkg::RW'(1) << ngss_pkg::FRAC_BITS;
      end else if (ctl.prep_en) begin
         unique case (ctl.prep_sel)
            ngss_pkg::OPD_LO: l_lo_ff  <= ngss_pkg::LW'(sum);
            ngss_pkg::OPD_HI: l_hi_ff  <= ngss_pkg::LW'(sum);
            default:          l_rng_ff <= ngss_pkg::LW'(sum);
         endcase
      end else if (ctl.r_step) begin
         r_ff <= sum;
      end
   end

   // Shared comparator against the current ladder value
   always_comb begin
      unique case (ctl.cmp_sel)
         ngss_pkg::CMP_LO_GT: l_cmp = l_lo_ff;
         ngss_pkg::CMP_HI_GE: l_cmp = l_hi_ff;
         default:             l_cmp = l_rng_ff;
      endcase
      cmp_a = ngss_pkg::CW'(l_cmp);
      if (ctl.cmp_sel == ngss_pkg::CMP_RANGE_TICKS) begin
         cmp_b = ngss_pkg::CW'(r_ff) * ngss_pkg::CW'(ngss_pkg::MIN_TICKS);
      end else begin
         cmp_b = ngss_pkg::CW'(r_ff);
      end
      a_gt    = cmp_a > cmp_b;
      a_eq    = cmp_a == cmp_b;
      ge_mode = (ctl.cmp_sel == ngss_pkg::CMP_RANGE_TICKS) ||
                (ctl.cmp_sel == ngss_pkg::CMP_HI_GE);
      hit     = a_gt | (ge_mode & a_eq);
   end

endmodule

`default_nettype wire

@@ sv/ngss_ctrl.sv @@
`default_nettype none

module ngss_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               in_empty,
   input  logic                               in_same,
   output ngss_pkg::ngss_arith_ctl_type       ctl,
   input  logic                               hit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ngss_pkg::MANT_W-1:0]        rsp_step_mantissa,
   output logic [ngss_pkg::EXP_W-1:0]         rsp_step_exponent,
   output logic                               rsp_range_empty,
   output logic                               rsp_saturated
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_PICK = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]                     state_ff,   state_in;
   logic [1:0]                     sel_ff,     sel_in;
   logic [ngss_pkg::PCNT_W-1:0]    pcnt_ff,    pcnt_in;
   logic [ngss_pkg::IDX_W-1:0]     j_ff,       j_in;
   logic [1:0]                     dig_ff,     dig_in;
   logic [1:0]                     phase_ff,   phase_in;
   logic                           any_ff,     any_in;
   logic [ngss_pkg::DEC_W-1:0]     cnt_dec_ff, cnt_dec_in;
   logic [ngss_pkg::IDX_W-1:0]     cnt8_ff,    cnt8_in;
   logic [ngss_pkg::IDX_W-1:0]     cnt_lo_ff,  cnt_lo_in;
   logic [ngss_pkg::IDX_W-1:0]     cnt_hi_ff,  cnt_hi_in;
   logic                           empty_ff,   empty_in;
   logic                           same_ff,    same_in;
   logic [ngss_pkg::IDX_W-1:0]     idx_ff,     idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ngss_pkg::MANT_W-1:0]    mant_ff,    mant_in;
   logic [ngss_pkg::EXP_W-1:0]     exp_ff,     exp_in;
   logic                           rempty_ff,  rempty_in;
   logic                           sat_ff,     sat_in;

   logic                           accept;
   logic                           slot_free;
   logic [ngss_pkg::DEC_W-1:0]     dec_clip;
   logic [ngss_pkg::IDX_W-1:0]     pidx;
   logic [ngss_pkg::IDX_W-1:0]     base_idx;
   logic                           below_min;
   logic                           above_max;
   ngss_pkg::ngss_split_type       split;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // Base step index from the decade count and the tick count
   always_comb begin
      dec_clip = (cnt_dec_ff > ngss_pkg::DEC_W'(ngss_pkg::TOP_BASE_DECADE)) ?
                 ngss_pkg::DEC_W'(ngss_pkg::TOP_BASE_DECADE) : cnt_dec_ff;
      pidx     = ngss_pkg::IDX_W'({dec_clip, 1'b0}) + ngss_pkg::IDX_W'(dec_clip);
      if (cnt8_ff == '0) begin
         base_idx = '0;
      end else if ((cnt8_ff - 1'b1) < pidx) begin
         base_idx = cnt8_ff - 1'b1;
      end else begin
         base_idx = pidx;
      end
      below_min = base_idx < cnt_lo_ff;
      above_max = base_idx >= cnt_hi_ff;
   end

   assign split = ngss_pkg::ngss_split(idx_ff);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      pcnt_in      = pcnt_ff;
      j_in         = j_ff;
      dig_in       = dig_ff;
      phase_in     = phase_ff;
      any_in       = any_ff;
      cnt_dec_in   = cnt_dec_ff;
      cnt8_in      = cnt8_ff;
      cnt_lo_in    = cnt_lo_ff;
      cnt_hi_in    = cnt_hi_ff;
      empty_in     = empty_ff;
      same_in      = same_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mant_in      = mant_ff;
      exp_in       = exp_ff;
      rempty_in    = rempty_ff;
      sat_in       = sat_ff;

      ctl          = '0;
      ctl.prep_sel = sel_ff;
      ctl.digit    = dig_ff;
      ctl.cmp_sel  = phase_ff;

      unique case (state_ff)
         ST_IDLE: begin
            ctl.load = accept;
            if (accept) begin
               empty_in = in_empty;
               same_in  = in_same;
               sel_in   = ngss_pkg::OPD_RANGE;
               pcnt_in  = '0;
               state_in = in_empty ? ST_EMIT : ST_PREP;
            end
         end

         // Scale range, min and max by 1e12, one multiply by ten a cycle
         ST_PREP: begin
            ctl.prep_en = 1'b1;
            if (pcnt_ff == ngss_pkg::PCNT_W'(ngss_pkg::SCALE_DIGITS - 1)) begin
               pcnt_in = '0;
               if (sel_ff == ngss_pkg::OPD_HI) begin
                  j_in       = '0;
                  dig_in     = ngss_pkg::MANT_ONE;
                  phase_in   = ngss_pkg::CMP_RANGE_GT;
                  any_in     = 1'b0;
                  cnt_dec_in = '0;
                  cnt8_in    = '0;
                  cnt_lo_in  = '0;
                  cnt_hi_in  = '0;
                  state_in   = ST_SCAN;
               end else if (sel_ff == ngss_pkg::OPD_RANGE) begin
                  sel_in = ngss_pkg::OPD_LO;
               end else begin
                  sel_in = ngss_pkg::OPD_HI;
               end
            end else begin
               pcnt_in = pcnt_ff + 1'b1;
            end
         end

         // Walk up the ladder, four compares per value, until none hit or it ends
         ST_SCAN: begin
            any_in = any_ff | hit;
            unique case (phase_ff)
               ngss_pkg::CMP_RANGE_GT: begin
                  if (hit && dig_ff == ngss_pkg::MANT_ONE &&
                      j_ff >= ngss_pkg::IDX_W'(ngss_pkg::DIGITS_PER_DECADE)) begin
                     cnt_dec_in = cnt_dec_ff + 1'b1;
                  end
                  phase_in = ngss_pkg::CMP_RANGE_TICKS;
               end
               ngss_pkg::CMP_RANGE_TICKS: begin
                  if (hit) cnt8_in = cnt8_ff + 1'b1;
                  phase_in = ngss_pkg::CMP_LO_GT;
               end
               ngss_pkg::CMP_LO_GT: begin
                  if (hit) cnt_lo_in = cnt_lo_ff + 1'b1;
                  phase_in = ngss_pkg::CMP_HI_GE;
               end
               ngss_pkg::CMP_HI_GE: begin
                  if (hit) cnt_hi_in = cnt_hi_ff + 1'b1;
                  ctl.r_step = 1'b1;
                  phase_in   = ngss_pkg::CMP_RANGE_GT;
                  any_in     = 1'b0;
                  if (!(any_ff | hit) ||
                      j_ff == ngss_pkg::IDX_W'(ngss_pkg::LADDER_LEN - 1)) begin
                     state_in = ST_PICK;
                  end else begin
                     j_in   = j_ff + 1'b1;
                     dig_in = (dig_ff == ngss_pkg::MANT_FIVE) ? ngss_pkg::MANT_ONE :
                              dig_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = ngss_pkg::CMP_RANGE_GT;
               end
            endcase
         end

         // Keep the base step or search up from min or down from max
         ST_PICK: begin
            priority if ((!below_min && !above_max) || same_ff) begin
               idx_in = base_idx;
            end else if (below_min) begin
               idx_in = (cnt_lo_ff == ngss_pkg::IDX_W'(ngss_pkg::LADDER_LEN)) ?
                        ngss_pkg::IDX_W'(ngss_pkg::LADDER_LEN - 1) : cnt_lo_ff;
            end else begin
               idx_in = (cnt_hi_ff == '0) ? '0 : cnt_hi_ff - 1'b1;
            end
            state_in = ST_EMIT;
         end

         // Hand the item to the output register once it is free
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rempty_in    = empty_ff;
               priority if (empty_ff) begin
                  mant_in = ngss_pkg::MANT_ONE;
                  exp_in  = '0;
                  sat_in  = 1'b0;
               end else if (split.decade < ngss_pkg::DEC_W'(ngss_pkg::DEC_SAT_LO)) begin
                  mant_in = ngss_pkg::MANT_ONE;
                  exp_in  = ngss_pkg::EXP_W'(ngss_pkg::OUT_EXP_LO);
                  sat_in  = 1'b1;
               end else if (split.decade > ngss_pkg::DEC_W'(ngss_pkg::DEC_SAT_HI)) begin
                  mant_in = ngss_pkg::MANT_FIVE;
                  exp_in  = ngss_pkg::EXP_W'(ngss_pkg::OUT_EXP_HI);
                  sat_in  = 1'b1;
               end else begin
                  mant_in = split.digit;
                  exp_in  = ngss_pkg::EXP_W'(split.decade) -
                            ngss_pkg::EXP_W'(ngss_pkg::SCALE_DIGITS);
                  sat_in  = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and payload
   always_ff @(posedge clock) begin
      sel_ff     <= sel_in;
      pcnt_ff    <= pcnt_in;
      j_ff       <= j_in;
      dig_ff     <= dig_in;
      phase_ff   <= phase_in;
      any_ff     <= any_in;
      cnt_dec_ff <= cnt_dec_in;
      cnt8_ff    <= cnt8_in;
      cnt_lo_ff  <= cnt_lo_in;
      cnt_hi_ff  <= cnt_hi_in;
      empty_ff   <= empty_in;
      same_ff    <= same_in;
      idx_ff     <= idx_in;
      mant_ff    <= mant_in;
      exp_ff     <= exp_in;
      rempty_ff  <= rempty_in;
      sat_ff     <= sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_mantissa = mant_ff;
   assign rsp_step_exponent = exp_ff;
   assign rsp_range_empty   = rempty_ff;
   assign rsp_saturated     = sat_ff;

endmodule

`default_nettype wire

@@ sv/nice_grid_step_select_core.sv @@
// Channel  | Handshake           | Payload
// request  | req_valid/req_ready | req_range_start, req_range_finish,
//          |                     | req_min_spacing, req_max_spacing (Q32.16)
// response | rsp_valid/rsp_ready | rsp_step_mantissa, rsp_step_exponent,
//          |                     | rsp_range_empty, rsp_saturated
//
// Empty range: the sequencer goes from idle straight to emit, which registers the result.
// Otherwise the three operands are first scaled by 1e12 through one shift-add unit,
// then each ladder value takes four compares (one shared comparator), walking up from
// 1e-12 until a value reaches the range and min spacing and exceeds the max spacing,
// or 99 values are done; then the pick state chooses the step and emit registers it.
// One item at a time; req_ready is high only when the sequencer is idle, while a
// finished item may still wait in the output register. Synchronous active-high reset.
`default_nettype none

module nice_grid_step_select_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ngss_pkg::IN_W-1:0]          req_range_start,
   input  logic [ngss_pkg::IN_W-1:0]          req_range_finish,
   input  logic [ngss_pkg::IN_W-1:0]          req_min_spacing,
   input  logic [ngss_pkg::IN_W-1:0]          req_max_spacing,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ngss_pkg::MANT_W-1:0]        rsp_step_mantissa,
   output logic signed [ngss_pkg::EXP_W-1:0]  rsp_step_exponent,
   output logic                               rsp_range_empty,
   output logic                               rsp_saturated
);

   logic [ngss_pkg::IN_W-1:0]      range_len;
   logic                           range_is_empty;
   logic                           spacing_same;
   logic                           hit;
   logic [ngss_pkg::EXP_W-1:0]     exp_raw;
   ngss_pkg::ngss_arith_ctl_type   ctl;

   // Range length and the special cases seen at the input
   assign range_is_empty = req_range_finish <= req_range_start;
   assign range_len      = req_range_finish - req_range_start;
   assign spacing_same   = req_min_spacing == req_max_spacing;

   ngss_arith u_arith (
      .clock    (clock),
      .ctl      (ctl),
      .rng_load (range_len),
      .lo_load  (req_min_spacing),
      .hi_load  (req_max_spacing),
      .hit      (hit)
   );

   ngss_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .in_empty          (range_is_empty),
      .in_same           (spacing_same),
      .ctl               (ctl),
      .hit               (hit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_step_mantissa (rsp_step_mantissa),
      .rsp_step_exponent (exp_raw),
      .rsp_range_empty   (rsp_range_empty),
      .rsp_saturated     (rsp_saturated)
   );

   assign rsp_step_exponent = $signed(exp_raw);

endmodule

`default_nettype wire

@@ sv/ngss_checker.sv @@
`default_nettype none

module ngss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [ngss_pkg::IN_W-1:0]          req_range_start,
   input logic [ngss_pkg::IN_W-1:0]          req_range_finish,
   input logic [ngss_pkg::IN_W-1:0]          req_min_spacing,
   input logic [ngss_pkg::IN_W-1:0]          req_max_spacing,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ngss_pkg::MANT_W-1:0]        rsp_step_mantissa,
   input logic signed [ngss_pkg::EXP_W-1:0]  rsp_step_exponent,
   input logic                               rsp_range_empty,
   input logic                               rsp_saturated
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_mantissa) &&
         $stable(rsp_step_exponent) && $stable(rsp_range_empty) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // Accepting an item makes the block busy in the next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block took a second item while busy");

   // An empty range yields step 1 without saturation
   a_empty_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_empty |->
         rsp_step_mantissa == ngss_pkg::MANT_ONE && rsp_step_exponent == '0 && !rsp_saturated)
      else $error("empty range did not yield step 1");

   // A saturated step sits at one end of the exponent range
   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_step_mantissa == ngss_pkg::MANT_ONE &&
          rsp_step_exponent == ngss_pkg::EXP_W'(ngss_pkg::OUT_EXP_LO)) ||
         (rsp_step_mantissa == ngss_pkg::MANT_FIVE &&
          rsp_step_exponent == ngss_pkg::EXP_W'(ngss_pkg::OUT_EXP_HI)))
      else $error("saturated step not at a range end");

   // Every step lies on the 1-2-5 ladder within the exponent range
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step_mantissa != 2'd3 &&
         rsp_step_exponent >= ngss_pkg::EXP_W'(ngss_pkg::OUT_EXP_LO) &&
         rsp_step_exponent <= ngss_pkg::EXP_W'(ngss_pkg::OUT_EXP_HI))
      else $error("step outside the exponent range");

endmodule

bind nice_grid_step_select_core ngss_checker u_ngss_checker (.*);

`default_nettype wire
